// ===== rtl/core/lwedn_pkg.sv =====
`default_nettype none

package lwedn_pkg;

  localparam int KEY_ENTRIES_DEF = 1024;

  localparam int RED_W = 65;
  localparam int CNT_W = 7;
  localparam int Q_W   = 33;

  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_MASK   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [31:0] MOD_RESET = 32'd1024;

  localparam logic [CNT_W-1:0] ACC_STEPS   = 7'd65;
  localparam logic [CNT_W-1:0] INNER_STEPS = 7'd32;
  localparam logic [CNT_W-1:0] FIN_STEPS   = 7'd36;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  index;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         plaintext;
    logic signed [35:0] noise;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
    logic [RED_W-1:0] value;
  } red_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
    logic [1:0]  qbits;
  } red_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_SUM,
    ST_ACC,
    ST_INNER,
    ST_TSUM,
    ST_FIN
  } st_t;

endpackage

`default_nettype wire

// ===== rtl/core/lwedn_ram.sv =====
`default_nettype none

module lwedn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/lwedn_modred.sv =====
`default_nettype none

module lwedn_modred
  import lwedn_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [Q_W-1:0] q,
  input  wire red_req_t       req,
  output red_rsp_t            rsp
);

  logic [RED_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [1:0]       qb_r, qb_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [Q_W-1:0]   trial;
  logic             ge;

  assign trial = {rem_r, sh_r[RED_W-1]};
  assign ge    = (trial >= q);

  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    qb_nxt   = qb_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      sh_nxt  = req.value;
      cnt_nxt = req.count;
      rem_nxt = '0;
      qb_nxt  = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      sh_nxt  = {sh_r[RED_W-2:0], 1'b0};
      rem_nxt = ge ? 32'(trial - q) : trial[31:0];
      qb_nxt  = {qb_r[0], ge};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    qb_r  <= qb_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.rem   = rem_r;
  assign rsp.qbits = qb_r;

endmodule

`default_nettype wire

// ===== rtl/core/lwe_decrypt_noise_top.sv =====
// LWE decryption with noise measurement.
// Input beats are taken on start while busy is low. A key-write beat stores a
// key word into the key memory and leaves busy low, so the next beat may follow
// in the next cycle. A mask beat reads the key word, multiplies it by the mask
// element and folds the product into the dot-product accumulator modulo q; the
// block stays busy through the read, multiply and reduction states. A finishing
// beat carries the body b; the result beat appears on out_valid and out_data
// after the reductions end, and the block takes the next beat in that same
// cycle. Operation code 3 is ignored.
// All reductions modulo q go through one shared restoring reducer that handles
// one bit a cycle: 65 steps for a mask element, 32 plus 36 for a finish. That
// reducer sets how long each beat keeps the block busy.
// The user must write the modulus register through cfg_we and cfg_wdata only
// while idle; the block does not enforce it. Zero means q equals two to the 32nd.
// Reset sets the modulus to 1024, clears the accumulator and returns to idle.
// The key memory is not cleared; every key word must be written before use.
// The receiver cannot stall: each result beat is valid for exactly one cycle.
`default_nettype none

module lwe_decrypt_noise_top
  import lwedn_pkg::*;
#(
  parameter int KEY_ENTRIES = KEY_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire in_item_t    in_data,
  output logic             busy,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(KEY_ENTRIES);

  st_t             state_r, state_nxt;
  logic [31:0]     modulus_r;
  logic [31:0]     val_r, val_nxt;
  logic            hit_r, hit_nxt;
  logic [63:0]     prod_r, prod_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [32:0]     bq_r, bq_nxt;
  logic [33:0]     t_r, t_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  logic [Q_W-1:0]  q_eff;
  logic            accept;
  logic            in_hit;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [31:0]     ram_rdata;
  logic [33:0]     noise_w;
  red_req_t        red_req;
  red_rsp_t        red_rsp;

  assign q_eff   = (modulus_r == '0) ? {1'b1, 32'b0} : {1'b0, modulus_r};
  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign in_hit  = ({22'b0, in_data.index} < 32'(KEY_ENTRIES));
  assign ram_we  = accept && (in_data.operation == OP_KEY) && in_hit;
  assign ram_addr = AW'(in_data.index);
  assign noise_w = {1'b0, red_rsp.rem, 1'b0} - {1'b0, q_eff};

  lwedn_ram #(
    .WIDTH (32),
    .DEPTH (KEY_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_data.value),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  lwedn_modred u_modred (
    .clk   (clk),
    .rst_n (rst_n),
    .q     (q_eff),
    .req   (red_req),
    .rsp   (red_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    hit_nxt       = hit_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    bq_nxt        = bq_r;
    t_nxt         = t_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    red_req.start = 1'b0;
    red_req.count = ACC_STEPS;
    red_req.value = 65'(prod_r) + 65'(acc_r);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_MASK: begin
              val_nxt   = in_data.value;
              hit_nxt   = in_hit;
              state_nxt = ST_RD;
            end
            OP_FINISH: begin
              bq_nxt        = {1'b0, in_data.value} + 33'(q_eff >> 3);
              red_req.start = 1'b1;
              red_req.count = INNER_STEPS;
              red_req.value = {acc_r, 33'b0};
              state_nxt     = ST_INNER;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        prod_nxt  = hit_r ? 64'(val_r) * 64'(ram_rdata) : '0;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        red_req.start = 1'b1;
        state_nxt     = ST_ACC;
      end
      ST_ACC: begin
        if (red_rsp.done) begin
          acc_nxt   = red_rsp.rem;
          state_nxt = ST_IDLE;
        end
      end
      ST_INNER: begin
        if (red_rsp.done) begin
          t_nxt     = 34'(bq_r) + 34'(q_eff) - 34'(red_rsp.rem);
          state_nxt = ST_TSUM;
        end
      end
      ST_TSUM: begin
        red_req.start = 1'b1;
        red_req.count = FIN_STEPS;
        red_req.value = {t_r, 2'b00, 29'b0};
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (red_rsp.done) begin
          out_valid_nxt     = 1'b1;
          out_nxt.plaintext = red_rsp.qbits;
          out_nxt.noise     = {{2{noise_w[33]}}, noise_w};
          acc_nxt           = '0;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MOD_RESET;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
    end
    val_r  <= val_nxt;
    hit_r  <= hit_nxt;
    prod_r <= prod_nxt;
    bq_r   <= bq_nxt;
    t_r    <= t_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FIN))
    else $error("result beat without a finished reduction");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (acc_r == '0) && !busy)
    else $error("accumulator not cleared after a result beat");

  a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    red_rsp.done |-> (state_r == ST_ACC || state_r == ST_INNER || state_r == ST_FIN))
    else $error("reducer finished outside a waiting state");
`endif

endmodule

`default_nettype wire
